// ----- src/sfr_pkg.sv -----
// Shared types, constants and helpers of the SBUS frame receiver.
// Used by sfr_front, sfr_back, the top level and the bench; depends on nothing.
`default_nettype none
package sfr_pkg;

    localparam int WIN_SIZE    = 35;
    localparam int FRAME_LEN   = 25;
    localparam int PACKET_LEN  = 35;
    localparam int INNER_OFS   = 8;
    localparam int CRC_LEN     = 33;
    localparam int NUM_CH      = 16;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0]  SYNC_BYTE  = 8'h0F;
    localparam logic [7:0]  HDR_BYTE0  = 8'hEB;
    localparam logic [7:0]  HDR_BYTE1  = 8'h90;
    localparam logic [7:0]  FLAG_BAD   = 8'h30;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;

    localparam logic [10:0] CENTER_RST = 11'd1500;
    localparam logic [9:0]  MARGIN_RST = 10'd100;
    localparam logic [10:0] PL_LOW_RST = 11'd915;
    localparam logic [11:0] PL_HI_RST  = 12'd2075;

    localparam logic [2:0] REG_CENTER = 3'd0;
    localparam logic [2:0] REG_MARGIN = 3'd1;
    localparam logic [2:0] REG_PL_LOW = 3'd2;
    localparam logic [2:0] REG_PL_HI  = 3'd3;

    typedef struct packed {
        logic [7:0] data;
        logic       is_hdr0;
        logic       is_hdr1;
        logic       is_sync;
        logic       is_zero;
    } rx_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOP,
        ST_FIND,
        ST_DECIDE,
        ST_CHECK,
        ST_EMIT
    } back_state_t;

    // Physical window address of a logical offset from the head (offset <= 35).
    function automatic logic [5:0] win_addr(input logic [5:0] head, input logic [5:0] ofs);
        logic [6:0] sum;
        sum = {1'b0, head} + {1'b0, ofs};
        if (sum >= 7'(WIN_SIZE))
            sum = sum - 7'(WIN_SIZE);
        return sum[5:0];
    endfunction

    // One byte of CRC-16/Modbus.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (crc[0])
                crc = (crc >> 1) ^ CRC_POLY;
            else
                crc = crc >> 1;
        end
        return crc;
    endfunction

endpackage
`default_nettype wire

// ----- src/sfr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package use.
`default_nettype none
module sfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 35
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- src/sfr_front.sv -----
// Front part: accepts received bytes, tags the sync, header and zero codes,
// and holds them in a short queue for the back part. Uses sfr_pkg.
`default_nettype none
module sfr_front #(
    parameter int DEPTH = sfr_pkg::QUEUE_DEPTH
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [7:0]           rx_byte,
    output logic                      q_valid,
    output sfr_pkg::rx_entry_t        q_data,
    input  wire logic                 q_pop
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    sfr_pkg::rx_entry_t entry_reg [DEPTH];
    logic [AW-1:0] wptr_reg, rptr_reg;
    logic [CW-1:0] cnt_reg;
    sfr_pkg::rx_entry_t tagged_item;
    logic push;

    always_comb
    begin
        tagged_item.data    = rx_byte;
        tagged_item.is_hdr0 = (rx_byte == sfr_pkg::HDR_BYTE0);
        tagged_item.is_hdr1 = (rx_byte == sfr_pkg::HDR_BYTE1);
        tagged_item.is_sync = (rx_byte == sfr_pkg::SYNC_BYTE);
        tagged_item.is_zero = (rx_byte == 8'h00);
    end

    assign in_stall = (cnt_reg == CW'(DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != '0);
    assign q_data   = entry_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wptr_reg] <= tagged_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            if (q_pop)
                rptr_reg <= (rptr_reg == AW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            cnt_reg <= cnt_reg + CW'(push) - CW'(q_pop);
        end
    end

endmodule
`default_nettype wire

// ----- src/sfr_back.sv -----
// Back part: byte window in RAM, resync scan, CRC and frame check, channel
// latch and result output register. Uses sfr_pkg and sfr_ram.
`default_nettype none
module sfr_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_valid,
    input  sfr_pkg::rx_entry_t        q_data,
    output logic                      q_pop,
    input  wire logic                 cfg_write,
    input  wire logic [2:0]           cfg_index,
    input  wire logic [11:0]          cfg_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [3:0]                channel_index,
    output logic [10:0]               channel_value,
    output logic [9:0]                button_bits,
    output logic                      was_wrapped,
    output logic                      last_of_frame
);

    localparam int EW = $bits(sfr_pkg::rx_entry_t);

    sfr_pkg::back_state_t state_reg, state_next;
    logic [5:0]  head_reg, head_next, count_reg, count_next;
    logic [5:0]  idx_reg, idx_next, pidx_reg, pidx_next;
    logic        pend_reg, pend_next;
    logic        prev_hdr_reg, prev_hdr_next;
    logic        hf_reg, hf_next, rf_reg, rf_next;
    logic [5:0]  h_reg, h_next, r_reg, r_next;
    logic        pkt_reg, pkt_next, ok_reg, ok_next;
    logic [15:0] crc_reg, crc_next;
    logic [18:0] acc_reg, acc_next;
    logic [4:0]  nb_reg, nb_next;
    logic [3:0]  ch_reg, ch_next, k_reg, k_next;
    logic [9:0]  btn_reg, btn_next;
    logic        wrap_reg, wrap_next;
    logic [10:0] center_reg, pl_low_reg;
    logic [9:0]  margin_reg;
    logic [11:0] pl_hi_reg;
    logic [10:0] latch_reg [sfr_pkg::NUM_CH];

    logic        ov_reg, ov_next;
    logic [3:0]  oidx_reg, oidx_next;
    logic [10:0] oval_reg, oval_next;
    logic [9:0]  obtn_reg, obtn_next;
    logic        owrap_reg, owrap_next, olast_reg, olast_next;

    logic        we, re;
    logic [5:0]  waddr, raddr, len;
    logic [EW-1:0] wdata;
    sfr_pkg::rx_entry_t rd;
    logic        latch_we;
    logic [10:0] latch_val;

    // Scratch values of the combinational block.
    logic [5:0]  cnt_a, fo, rel;
    logic        drop_h, hdr_front, in_frame, done;
    logic [18:0] sum;
    logic [10:0] v;
    logic signed [12:0] v13, c13, lo13, hi13;

    sfr_ram #(.WIDTH(EW), .DEPTH(sfr_pkg::WIN_SIZE)) u_win (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rd)
    );

    assign wdata         = q_data;
    assign out_valid     = ov_reg;
    assign channel_index = oidx_reg;
    assign channel_value = oval_reg;
    assign button_bits   = obtn_reg;
    assign was_wrapped   = owrap_reg;
    assign last_of_frame = olast_reg;

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        pidx_next     = pidx_reg;
        pend_next     = 1'b0;
        prev_hdr_next = prev_hdr_reg;
        hf_next       = hf_reg;
        rf_next       = rf_reg;
        h_next        = h_reg;
        r_next        = r_reg;
        pkt_next      = pkt_reg;
        ok_next       = ok_reg;
        crc_next      = crc_reg;
        acc_next      = acc_reg;
        nb_next       = nb_reg;
        ch_next       = ch_reg;
        k_next        = k_reg;
        btn_next      = btn_reg;
        wrap_next     = wrap_reg;
        ov_next       = ov_reg && out_stall;
        oidx_next     = oidx_reg;
        oval_next     = oval_reg;
        obtn_next     = obtn_reg;
        owrap_next    = owrap_reg;
        olast_next    = olast_reg;
        q_pop         = 1'b0;
        we            = 1'b0;
        waddr         = sfr_pkg::win_addr(head_reg, count_reg);
        re            = 1'b0;
        raddr         = sfr_pkg::win_addr(head_reg, idx_reg);
        latch_we      = 1'b0;
        latch_val     = '0;
        cnt_a         = count_reg;
        drop_h        = 1'b0;
        hdr_front     = 1'b0;
        fo            = pkt_reg ? 6'(sfr_pkg::INNER_OFS) : 6'd0;
        rel           = pidx_reg - fo;
        in_frame      = (pidx_reg >= fo) && (rel < 6'(sfr_pkg::FRAME_LEN));
        sum           = acc_reg | (19'(rd.data) << nb_reg);
        v             = sum[10:0];
        v13           = $signed({2'b00, v});
        c13           = $signed({2'b00, center_reg});
        lo13          = c13 - $signed({3'b000, margin_reg});
        hi13          = c13 + $signed({3'b000, margin_reg});
        len           = count_reg;
        done          = 1'b0;

        case (state_reg)
            sfr_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    we    = 1'b1;
                    // A full window loses its oldest byte; the new one takes its slot.
                    if (count_reg == 6'(sfr_pkg::WIN_SIZE))
                    begin
                        waddr     = head_reg;
                        head_next = sfr_pkg::win_addr(head_reg, 6'd1);
                    end
                    else
                        count_next = count_reg + 6'd1;
                    state_next = sfr_pkg::ST_LOOP;
                end
            end

            sfr_pkg::ST_LOOP:
            begin
                if (count_reg >= 6'(sfr_pkg::FRAME_LEN))
                begin
                    idx_next      = '0;
                    prev_hdr_next = 1'b0;
                    hf_next       = 1'b0;
                    rf_next       = 1'b0;
                    state_next    = sfr_pkg::ST_FIND;
                end
                else
                    state_next = sfr_pkg::ST_IDLE;
            end

            sfr_pkg::ST_FIND:
            begin
                len = count_reg;
                if (idx_reg < len)
                begin
                    re        = 1'b1;
                    idx_next  = idx_reg + 6'd1;
                    pend_next = 1'b1;
                    pidx_next = idx_reg;
                end
                if (pend_reg)
                begin
                    if (!hf_reg && prev_hdr_reg && rd.is_hdr1)
                    begin
                        hf_next = 1'b1;
                        h_next  = pidx_reg - 6'd1;
                    end
                    if (!rf_reg && rd.is_sync)
                    begin
                        rf_next = 1'b1;
                        r_next  = pidx_reg;
                    end
                    prev_hdr_next = rd.is_hdr0;
                    if (pidx_reg == len - 6'd1)
                        state_next = sfr_pkg::ST_DECIDE;
                end
            end

            sfr_pkg::ST_DECIDE:
            begin
                drop_h    = hf_reg && (h_reg != '0) && (!rf_reg || (h_reg < r_reg));
                hdr_front = hf_reg && ((h_reg == '0) || drop_h);
                idx_next  = '0;
                crc_next  = sfr_pkg::CRC_INIT;
                acc_next  = '0;
                nb_next   = '0;
                ch_next   = '0;
                btn_next  = '0;
                ok_next   = 1'b1;
                if (hdr_front)
                begin
                    if (drop_h)
                    begin
                        head_next = sfr_pkg::win_addr(head_reg, h_reg);
                        cnt_a     = count_reg - h_reg;
                    end
                    count_next = cnt_a;
                    pkt_next   = 1'b1;
                    state_next = (cnt_a < 6'(sfr_pkg::PACKET_LEN)) ? sfr_pkg::ST_IDLE
                                                                  : sfr_pkg::ST_CHECK;
                end
                else if (!rf_reg)
                begin
                    count_next = '0;
                    state_next = sfr_pkg::ST_IDLE;
                end
                else
                begin
                    head_next  = sfr_pkg::win_addr(head_reg, r_reg);
                    cnt_a      = count_reg - r_reg;
                    count_next = cnt_a;
                    pkt_next   = 1'b0;
                    state_next = (cnt_a < 6'(sfr_pkg::FRAME_LEN)) ? sfr_pkg::ST_IDLE
                                                                 : sfr_pkg::ST_CHECK;
                end
            end

            sfr_pkg::ST_CHECK:
            begin
                len = pkt_reg ? 6'(sfr_pkg::PACKET_LEN) : 6'(sfr_pkg::FRAME_LEN);
                if (idx_reg < len)
                begin
                    re        = 1'b1;
                    idx_next  = idx_reg + 6'd1;
                    pend_next = 1'b1;
                    pidx_next = idx_reg;
                end
                if (pend_reg)
                begin
                    if (pkt_reg && (pidx_reg < 6'(sfr_pkg::CRC_LEN)))
                        crc_next = sfr_pkg::crc_byte(crc_reg, rd.data);
                    if (pkt_reg && (pidx_reg == 6'(sfr_pkg::CRC_LEN)) &&
                        (rd.data != crc_reg[7:0]))
                        ok_next = 1'b0;
                    if (pkt_reg && (pidx_reg == 6'(sfr_pkg::CRC_LEN + 1)) &&
                        (rd.data != crc_reg[15:8]))
                        ok_next = 1'b0;
                    if (in_frame)
                    begin
                        if ((rel == 6'd0) && !rd.is_sync)
                            ok_next = 1'b0;
                        if ((rel == 6'd24) && !rd.is_zero)
                            ok_next = 1'b0;
                        if (rel == 6'd23)
                        begin
                            if ((rd.data & sfr_pkg::FLAG_BAD) != 8'h00)
                                ok_next = 1'b0;
                            btn_next[8] = rd.data[7];
                            btn_next[9] = rd.data[6];
                        end
                        if ((rel >= 6'd1) && (rel <= 6'd22))
                        begin
                            // Eight new bits per byte: at most one channel completes.
                            if (nb_reg >= 5'd3)
                            begin
                                latch_we  = 1'b1;
                                latch_val = v;
                                acc_next  = sum >> 11;
                                nb_next   = nb_reg - 5'd3;
                                ch_next   = ch_reg + 4'd1;
                                if ((v < pl_low_reg) || ({1'b0, v} > pl_hi_reg))
                                    ok_next = 1'b0;
                                case (ch_reg)
                                    4'd10:
                                    begin
                                        btn_next[0] = (v13 < lo13);
                                        btn_next[1] = (v13 > hi13);
                                    end
                                    4'd11:
                                    begin
                                        btn_next[2] = (v13 < lo13);
                                        btn_next[3] = (v13 > hi13);
                                    end
                                    4'd12:   btn_next[4] = (v13 > c13);
                                    4'd13:   btn_next[5] = (v13 > c13);
                                    4'd14:   btn_next[6] = (v13 < c13);
                                    4'd15:   btn_next[7] = (v13 > c13);
                                    default: ;
                                endcase
                            end
                            else
                            begin
                                acc_next = sum;
                                nb_next  = nb_reg + 5'd8;
                            end
                        end
                    end
                    done = (pidx_reg == len - 6'd1);
                    if (done)
                    begin
                        if (ok_next)
                        begin
                            head_next  = sfr_pkg::win_addr(head_reg, len);
                            count_next = count_reg - len;
                            wrap_next  = pkt_reg;
                            k_next     = '0;
                            state_next = sfr_pkg::ST_EMIT;
                        end
                        else
                        begin
                            head_next  = sfr_pkg::win_addr(head_reg, 6'd1);
                            count_next = count_reg - 6'd1;
                            state_next = sfr_pkg::ST_LOOP;
                        end
                    end
                end
            end

            sfr_pkg::ST_EMIT:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next    = 1'b1;
                    oidx_next  = k_reg;
                    oval_next  = latch_reg[k_reg];
                    obtn_next  = btn_reg;
                    owrap_next = wrap_reg;
                    olast_next = (k_reg == 4'(sfr_pkg::NUM_CH - 1));
                    k_next     = k_reg + 4'd1;
                    if (k_reg == 4'(sfr_pkg::NUM_CH - 1))
                        state_next = sfr_pkg::ST_IDLE;
                end
            end

            default:
                state_next = sfr_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (latch_we)
            latch_reg[ch_reg] <= latch_val;
        idx_reg  <= idx_next;
        pidx_reg <= pidx_next;
        prev_hdr_reg <= prev_hdr_next;
        hf_reg   <= hf_next;
        rf_reg   <= rf_next;
        h_reg    <= h_next;
        r_reg    <= r_next;
        pkt_reg  <= pkt_next;
        ok_reg   <= ok_next;
        crc_reg  <= crc_next;
        acc_reg  <= acc_next;
        nb_reg   <= nb_next;
        ch_reg   <= ch_next;
        k_reg    <= k_next;
        wrap_reg <= wrap_next;
        oidx_reg <= oidx_next;
        oval_reg <= oval_next;
        obtn_reg <= obtn_next;
        owrap_reg <= owrap_next;
        olast_reg <= olast_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= sfr_pkg::ST_IDLE;
            head_reg   <= '0;
            count_reg  <= '0;
            pend_reg   <= 1'b0;
            btn_reg    <= '0;
            ov_reg     <= 1'b0;
            center_reg <= sfr_pkg::CENTER_RST;
            margin_reg <= sfr_pkg::MARGIN_RST;
            pl_low_reg <= sfr_pkg::PL_LOW_RST;
            pl_hi_reg  <= sfr_pkg::PL_HI_RST;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            btn_reg   <= btn_next;
            ov_reg    <= ov_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    sfr_pkg::REG_CENTER: center_reg <= cfg_data[10:0];
                    sfr_pkg::REG_MARGIN: margin_reg <= cfg_data[9:0];
                    sfr_pkg::REG_PL_LOW: pl_low_reg <= cfg_data[10:0];
                    sfr_pkg::REG_PL_HI:  pl_hi_reg  <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule
`default_nettype wire

// ----- src/sbus_frame_receiver_top.sv -----
// Top level of the SBUS frame receiver: byte queue front and window back.
// Depends on sfr_pkg, sfr_front, sfr_back and sfr_ram.
//
//  channel | handshake            | payload
//  input   | in_valid / in_stall  | rx_byte
//  output  | out_valid / out_stall| channel_index, channel_value, button_bits,
//          |                      | was_wrapped, last_of_frame
//  config  | cfg_write            | cfg_index, cfg_data
//
// Each byte passes through the idle and loop states; from 25 held bytes on it adds a
// window sweep, a decision state and, for a candidate, a check sweep; each rejected
// candidate passes the loop state again and repeats both sweeps. Single-port RAM reads set this.
// An accepted frame then emits its 16 channel results, held while the output side stalls.
// Reset empties the window and the queue; the RAM needs no clearing pass.
// Output stalls hold the result register; the byte queue keeps taking items until it is full.
`default_nettype none
module sbus_frame_receiver_top #(
    parameter int QUEUE_DEPTH = sfr_pkg::QUEUE_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [3:0]       channel_index,
    output logic [10:0]      channel_value,
    output logic [9:0]       button_bits,
    output logic             was_wrapped,
    output logic             last_of_frame,
    input  wire logic        cfg_write,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [11:0] cfg_data
);

    logic q_valid, q_pop;
    sfr_pkg::rx_entry_t q_data;

    sfr_front #(.DEPTH(QUEUE_DEPTH)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .rx_byte  (rx_byte),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop)
    );

    sfr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_data        (q_data),
        .q_pop         (q_pop),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .channel_index (channel_index),
        .channel_value (channel_value),
        .button_bits   (button_bits),
        .was_wrapped   (was_wrapped),
        .last_of_frame (last_of_frame)
    );

endmodule
`default_nettype wire

// ----- src/sfr_checker.sv -----
// Port-level checks of the SBUS frame receiver, bound to the top level.
// Depends on sbus_frame_receiver_top ports only.
`default_nettype none
module sfr_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [3:0]  channel_index,
    input wire logic [10:0] channel_value,
    input wire logic [9:0]  button_bits,
    input wire logic        was_wrapped,
    input wire logic        last_of_frame
);

    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(channel_value) &&
        $stable(channel_index) && $stable(button_bits))
        else $error("stalled result changed");

    // The last flag marks exactly the sixteenth channel.
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_of_frame == (channel_index == 4'd15)))
        else $error("last flag and channel index disagree");

    // Within a frame, the next result continues the same frame.
    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_frame |=> !out_valid ||
        ((channel_index == $past(channel_index) + 4'd1) &&
         (button_bits == $past(button_bits)) && (was_wrapped == $past(was_wrapped))))
        else $error("frame results out of sequence");

endmodule

bind sbus_frame_receiver_top sfr_checker u_sfr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .channel_index (channel_index),
    .channel_value (channel_value),
    .button_bits   (button_bits),
    .was_wrapped   (was_wrapped),
    .last_of_frame (last_of_frame)
);
`default_nettype wire

// ----- bench/sbus_frame_receiver_top_test.sv -----
// Self-checking bench for sbus_frame_receiver_top: raw frames, EB90 packets and noise.
// Depends on sfr_pkg and the receiver RTL; predicts channel results and compares them.
`default_nettype none
module sbus_frame_receiver_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Register indexes that select no register.
    localparam logic [2:0] REG_SPARE_LO = 3'd4;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    typedef struct {
        logic [3:0]  idx;
        logic [10:0] val;
        logic [9:0]  btn;
        logic        wrap;
        logic        last;
    } channel_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_stall;
    logic [3:0]  channel_index;
    logic [10:0] channel_value;
    logic [9:0]  button_bits;
    logic        was_wrapped;
    logic        last_of_frame;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic [11:0] cfg_data;

    sbus_frame_receiver_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
        .out_valid(out_valid), .out_stall(out_stall),
        .channel_index(channel_index), .channel_value(channel_value),
        .button_bits(button_bits), .was_wrapped(was_wrapped),
        .last_of_frame(last_of_frame),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Predictor state.
    logic [7:0]  win_bytes [sfr_pkg::WIN_SIZE];
    int          win_fill;
    logic [10:0] latched_ch [sfr_pkg::NUM_CH];
    logic [9:0]  latched_btn;
    logic [10:0] center;
    logic [9:0]  margin;
    logic [10:0] lim_low;
    logic [11:0] lim_high;

    channel_result_t expected_channels[$];
    logic [7:0]      byte_q[$];
    int              mismatches;
    int              in_gap;
    int              out_gap;
    bit              in_quiet;
    bit              out_quiet;
    int              idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int pick_gap(inout bit quiet);
        int r;
        if ($urandom_range(0, 49) == 0)
            quiet = ~quiet;
        if (quiet)
            return 0;
        r = int'($urandom_range(0, 99));
        if (r < 60)
            return 0;
        if (r < 92)
            return int'($urandom_range(1, 3));
        return int'($urandom_range(10, 50));
    endfunction

    function automatic logic [15:0] modbus_crc(logic [7:0] data [], int len);
        logic [15:0] crc;
        crc = sfr_pkg::CRC_INIT;
        for (int i = 0; i < len; i++)
        begin
            crc ^= {8'h00, data[i]};
            for (int k = 0; k < 8; k++)
                crc = crc[0] ? ((crc >> 1) ^ sfr_pkg::CRC_POLY) : (crc >> 1);
        end
        return crc;
    endfunction

    function automatic void window_drop(int n);
        if (n >= win_fill)
        begin
            win_fill = 0;
            return;
        end
        for (int i = 0; i < win_fill - n; i++)
            win_bytes[i] = win_bytes[i + n];
        win_fill -= n;
    endfunction

    function automatic int find_header();
        for (int i = 0; i + 1 < win_fill; i++)
            if (win_bytes[i] == sfr_pkg::HDR_BYTE0 && win_bytes[i + 1] == sfr_pkg::HDR_BYTE1)
                return i;
        return -1;
    endfunction

    function automatic int find_sync();
        for (int i = 0; i < win_fill; i++)
            if (win_bytes[i] == sfr_pkg::SYNC_BYTE)
                return i;
        return -1;
    endfunction

    // Checks the frame at base and latches its channels and buttons when good.
    function automatic bit decode_frame_at(int base);
        logic [10:0] ch [sfr_pkg::NUM_CH];
        logic [7:0]  flags;
        logic [9:0]  btn;
        int          pos;
        int          lo_th;
        int          hi_th;
        int          c;
        if (win_bytes[base] != sfr_pkg::SYNC_BYTE || win_bytes[base + 24] != 8'h00)
            return 0;
        for (int i = 0; i < sfr_pkg::NUM_CH; i++)
        begin
            for (int b = 0; b < 11; b++)
            begin
                pos = i * 11 + b;
                ch[i][b] = win_bytes[base + 1 + pos / 8][pos % 8];
            end
            if (ch[i] < lim_low || {1'b0, ch[i]} > lim_high)
                return 0;
        end
        flags = win_bytes[base + 23];
        if ((flags & sfr_pkg::FLAG_BAD) != 0)
            return 0;
        c = int'(center);
        lo_th = c - int'(margin);
        hi_th = c + int'(margin);
        btn = '0;
        btn[0] = int'(ch[10]) < lo_th;
        btn[1] = int'(ch[10]) > hi_th;
        btn[2] = int'(ch[11]) < lo_th;
        btn[3] = int'(ch[11]) > hi_th;
        btn[4] = int'(ch[12]) > c;
        btn[5] = int'(ch[13]) > c;
        btn[6] = int'(ch[14]) < c;
        btn[7] = int'(ch[15]) > c;
        btn[8] = flags[7];
        btn[9] = flags[6];
        latched_ch = ch;
        latched_btn = btn;
        return 1;
    endfunction

    // Returns 0 when nothing is found, 1 for a raw frame, 2 for a wrapped one.
    function automatic int scan_window();
        int h;
        int s;
        int r;
        logic [7:0]  pkt [];
        logic [15:0] want;
        while (win_fill >= sfr_pkg::FRAME_LEN)
        begin
            h = find_header();
            if (h > 0)
            begin
                r = find_sync();
                if (r < 0 || h < r)
                    window_drop(h);
            end
            if (win_fill >= 2 && win_bytes[0] == sfr_pkg::HDR_BYTE0 &&
                win_bytes[1] == sfr_pkg::HDR_BYTE1)
            begin
                if (win_fill < sfr_pkg::PACKET_LEN)
                    return 0;
                pkt = new[sfr_pkg::CRC_LEN];
                for (int i = 0; i < sfr_pkg::CRC_LEN; i++)
                    pkt[i] = win_bytes[i];
                want = {win_bytes[sfr_pkg::PACKET_LEN - 1], win_bytes[sfr_pkg::PACKET_LEN - 2]};
                if (modbus_crc(pkt, sfr_pkg::CRC_LEN) == want &&
                    decode_frame_at(sfr_pkg::INNER_OFS))
                begin
                    window_drop(sfr_pkg::PACKET_LEN);
                    return 2;
                end
                window_drop(1);
                continue;
            end
            s = find_sync();
            if (s < 0)
            begin
                win_fill = 0;
                return 0;
            end
            if (s > 0)
                window_drop(s);
            if (win_fill < sfr_pkg::FRAME_LEN)
                return 0;
            if (decode_frame_at(0))
            begin
                window_drop(sfr_pkg::FRAME_LEN);
                return 1;
            end
            window_drop(1);
        end
        return 0;
    endfunction

    function automatic void predict_byte(logic [7:0] b);
        int kind;
        channel_result_t res;
        if (win_fill >= sfr_pkg::WIN_SIZE)
            window_drop(1);
        win_bytes[win_fill] = b;
        win_fill++;
        kind = scan_window();
        if (kind == 0)
            return;
        for (int k = 0; k < sfr_pkg::NUM_CH; k++)
        begin
            res.idx = 4'(k);
            res.val = latched_ch[k];
            res.btn = latched_btn;
            res.wrap = (kind == 2);
            res.last = (k == sfr_pkg::NUM_CH - 1);
            expected_channels.push_back(res);
        end
    endfunction

    // Byte driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            rx_byte <= 8'h00;
            in_gap <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_byte(rx_byte);
            if (!in_valid || !in_stall)
            begin
                if (in_gap > 0)
                begin
                    in_gap <= in_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (byte_q.size() > 0)
                begin
                    rx_byte <= byte_q.pop_front();
                    in_valid <= 1'b1;
                    in_gap <= pick_gap(in_quiet);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result monitor and output stall generator.
    always @(posedge clk or negedge rst_n)
    begin
        channel_result_t exp_r;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_gap <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_channels.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: idx %0d val %0d btn %h wrap %b last %b",
                                 channel_index, channel_value, button_bits,
                                 was_wrapped, last_of_frame);
                end
                else
                begin
                    exp_r = expected_channels.pop_front();
                    if (exp_r.idx !== channel_index || exp_r.val !== channel_value ||
                        exp_r.btn !== button_bits || exp_r.wrap !== was_wrapped ||
                        exp_r.last !== last_of_frame)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("mismatch: expected idx %0d val %0d btn %h wrap %b last %b",
                                     exp_r.idx, exp_r.val, exp_r.btn, exp_r.wrap, exp_r.last);
                            $display("          actual   idx %0d val %0d btn %h wrap %b last %b",
                                     channel_index, channel_value, button_bits,
                                     was_wrapped, last_of_frame);
                        end
                    end
                end
            end
            if (out_gap > 0)
            begin
                out_gap <= out_gap - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_gap <= pick_gap(out_quiet);
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: too long without any accepted item on either side.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles > 200000)
            begin
                $display("sbus_frame_receiver_top_test: FAIL");
                $finish;
            end
        end
    end

    function automatic void push_frame(logic [10:0] ch [sfr_pkg::NUM_CH], logic [7:0] flags,
                                       logic [7:0] tail, bit wrap, bit bad_crc);
        logic [7:0]  fr [];
        logic [15:0] crc;
        int          pos;
        int          ofs;
        ofs = wrap ? sfr_pkg::INNER_OFS : 0;
        fr = new[wrap ? sfr_pkg::PACKET_LEN : sfr_pkg::FRAME_LEN];
        if (wrap)
        begin
            fr[0] = sfr_pkg::HDR_BYTE0;
            fr[1] = sfr_pkg::HDR_BYTE1;
            for (int i = 2; i < sfr_pkg::INNER_OFS; i++)
                fr[i] = 8'($urandom);
        end
        for (int i = 1; i <= 22; i++)
            fr[ofs + i] = 8'h00;
        fr[ofs] = sfr_pkg::SYNC_BYTE;
        for (int i = 0; i < sfr_pkg::NUM_CH; i++)
            for (int b = 0; b < 11; b++)
            begin
                pos = i * 11 + b;
                fr[ofs + 1 + pos / 8][pos % 8] = ch[i][b];
            end
        fr[ofs + 23] = flags;
        fr[ofs + 24] = tail;
        if (wrap)
        begin
            crc = modbus_crc(fr, sfr_pkg::CRC_LEN);
            if (bad_crc)
                crc ^= 16'(1 << $urandom_range(0, 15));
            fr[33] = crc[7:0];
            fr[34] = crc[15:8];
        end
        foreach (fr[i])
            byte_q.push_back(fr[i]);
    endfunction

    function automatic logic [10:0] pick_channel();
        int lo;
        int hi;
        int c;
        lo = int'(lim_low);
        hi = (lim_high > 12'd2047) ? 2047 : int'(lim_high);
        if (lo > hi || $urandom_range(0, 9) == 0)
            return 11'($urandom);
        c = int'(center);
        if ($urandom_range(0, 2) == 0)
        begin
            c = c + int'($urandom_range(0, 2)) - 1
                + ($urandom_range(0, 1) ? int'(margin) : 0)
                - ($urandom_range(0, 1) ? int'(margin) : 0);
            if (c >= lo && c <= hi)
                return 11'(c);
        end
        return 11'($urandom_range(lo, hi));
    endfunction

    // Mostly good frames and packets with random content, plus broken ones and noise.
    task automatic random_traffic(int n);
        logic [10:0] ch [sfr_pkg::NUM_CH];
        logic [7:0]  flags;
        int          kind;
        for (int f = 0; f < n; f++)
        begin
            foreach (ch[i])
                ch[i] = pick_channel();
            flags = 8'($urandom) & 8'hCF;
            kind = int'($urandom_range(0, 9));
            case (kind)
                0, 1, 2: push_frame(ch, flags, 8'h00, 1'b0, 1'b0);
                3, 4:    push_frame(ch, flags, 8'h00, 1'b1, 1'b0);
                5:       push_frame(ch, flags, 8'h00, 1'b1, 1'b1);
                6:       push_frame(ch, flags | 8'(8'h10 << $urandom_range(0, 1)), 8'h00,
                                    1'($urandom_range(0, 1)), 1'b0);
                7:       push_frame(ch, flags, 8'($urandom_range(1, 255)), 1'b0, 1'b0);
                default:
                begin
                    ch[4'($urandom_range(0, 15))] = 11'($urandom);
                    push_frame(ch, flags, 8'h00, 1'($urandom_range(0, 1)), 1'b0);
                end
            endcase
            repeat ($urandom_range(0, 3))
                byte_q.push_back(8'($urandom));
            if ($urandom_range(0, 5) == 0)
            begin
                byte_q.push_back(sfr_pkg::HDR_BYTE0);
                byte_q.push_back(sfr_pkg::HDR_BYTE1);
            end
        end
    endtask

    task automatic write_reg(logic [2:0] idx, logic [11:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            sfr_pkg::REG_CENTER: center = value[10:0];
            sfr_pkg::REG_MARGIN: margin = value[9:0];
            sfr_pkg::REG_PL_LOW: lim_low = value[10:0];
            sfr_pkg::REG_PL_HI:  lim_high = value;
            default: ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Waits until every byte is in and every result out, then lets a rejected
    // candidate sweep finish before registers change.
    task automatic drain();
        while (byte_q.size() > 0 || in_valid || expected_channels.size() > 0)
            @(posedge clk);
        repeat (5000) @(posedge clk);
    endtask

    initial
    begin
        logic [10:0] ch [sfr_pkg::NUM_CH];
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        center = sfr_pkg::CENTER_RST;
        margin = sfr_pkg::MARGIN_RST;
        lim_low = sfr_pkg::PL_LOW_RST;
        lim_high = sfr_pkg::PL_HI_RST;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: low limit exactly, then a stray sync before the EB90 of a wrapped packet.
        foreach (ch[i])
            ch[i] = i[0] ? 11'd2047 : 11'd915;
        ch[0] = 11'd915;
        byte_q.push_back(8'hFF);
        push_frame(ch, 8'hC0, 8'h00, 1'b0, 1'b0);
        foreach (ch[i])
            ch[i] = 11'd1500 + 11'(i * 20);
        byte_q.push_back(sfr_pkg::SYNC_BYTE);
        byte_q.push_back(8'h00);
        push_frame(ch, 8'h00, 8'h00, 1'b1, 1'b0);
        drain();

        // Negative low threshold and the widest limits.
        write_reg(sfr_pkg::REG_CENTER, 12'd0);
        write_reg(sfr_pkg::REG_MARGIN, 12'd1023);
        write_reg(sfr_pkg::REG_PL_LOW, 12'd0);
        write_reg(sfr_pkg::REG_PL_HI, 12'd4095);
        foreach (ch[i])
            ch[i] = i[0] ? 11'd2047 : 11'd0;
        push_frame(ch, 8'hFF & 8'hCF, 8'h00, 1'b0, 1'b0);
        drain();

        // Top centre, zero margin, masked data, ignored indexes, single legal value.
        write_reg(sfr_pkg::REG_CENTER, 12'hFFF);
        write_reg(sfr_pkg::REG_MARGIN, 12'd0);
        write_reg(sfr_pkg::REG_PL_LOW, 12'hFFF);
        write_reg(sfr_pkg::REG_PL_HI, 12'd2047);
        write_reg(REG_SPARE_LO, 12'h555);
        write_reg(REG_SPARE_HI, 12'hAAA);
        foreach (ch[i])
            ch[i] = 11'd2047;
        push_frame(ch, 8'h40, 8'h00, 1'b1, 1'b0);
        drain();

        // Crossed limits reject everything.
        write_reg(sfr_pkg::REG_PL_LOW, 12'd1500);
        write_reg(sfr_pkg::REG_PL_HI, 12'd1000);
        random_traffic(1);
        drain();

        write_reg(sfr_pkg::REG_CENTER, 12'd1024);
        write_reg(sfr_pkg::REG_MARGIN, 12'd300);
        write_reg(sfr_pkg::REG_PL_LOW, 12'd172);
        write_reg(sfr_pkg::REG_PL_HI, 12'd1811);
        random_traffic(1);
        drain();

        if (mismatches == 0 && expected_channels.size() == 0)
            $display("sbus_frame_receiver_top_test: PASS");
        else
            $display("sbus_frame_receiver_top_test: FAIL");
        $finish;
    end

endmodule
`default_nettype wire
